// ===== rtl/tgd_pkg.sv =====
// shared types and constants of the touch gesture detector
`default_nettype none

package tgd_pkg;

    localparam int unsigned CFG_W     = 16;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned TIME_W    = 32;
    localparam int unsigned COUNT_W   = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE    = 2'd0,
        CFG_LONG_PRESS  = 2'd1,
        CFG_MULTI_CLICK = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        EV_SERIES_END = 2'd0,
        EV_LONG_START = 2'd1,
        EV_LONG_END   = 2'd2
    } t_event_kind;

    localparam logic [CFG_W-1:0] DEBOUNCE_RST    = 16'd50;
    localparam logic [CFG_W-1:0] LONG_PRESS_RST  = 16'd1000;
    localparam logic [CFG_W-1:0] MULTI_CLICK_RST = 16'd400;

endpackage

`default_nettype wire

// ===== rtl/tgd_in_if.sv =====
// input channel: one poll of the touch pad
`default_nettype none

interface tgd_in_if;
    import tgd_pkg::*;

    logic              valid;
    logic              ready;
    logic              touch_level;
    logic [TIME_W-1:0] now_ms;

    modport source (output valid, output touch_level, output now_ms, input ready);
    modport sink   (input valid, input touch_level, input now_ms, output ready);
endinterface

`default_nettype wire

// ===== rtl/tgd_out_if.sv =====
// output channel: one gesture event
`default_nettype none

interface tgd_out_if;
    import tgd_pkg::*;

    logic               valid;
    logic               ready;
    t_event_kind        event_kind;
    logic [COUNT_W-1:0] click_count;

    modport source (output valid, output event_kind, output click_count, input ready);
    modport sink   (input valid, input event_kind, input click_count, output ready);
endinterface

`default_nettype wire

// ===== rtl/touch_gesture_detector_unit.sv =====
// touch gesture detector: click series, long press and long press release events
//
// i_in carries one poll of the pad (touch_level, now_ms); a transfer happens when
// valid and ready are both high. o_out carries events (event_kind, click_count);
// a poll gives at most one event. click_count is zero except for series end.
// configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx
// (0 debounce, 1 long press, 2 multi click, all in ms); write only while idle.
// a poll is registered in the input stage and evaluated against the tracking
// state; its event, if any, is written to the output register and made valid on
// o_out when the input stage advances.
// throughput: one poll per cycle; the input stage advances whenever the output
// register is empty or being taken, so polls flow back to back while the
// receiver keeps up.
// when the receiver stalls, the output register holds its event and the input
// stage holds one more poll; i_in.ready drops only when both are full.
// reset (synchronous, active low) restores the default thresholds and clears
// all tracking state: released, no press pending, no clicks counted.
`default_nettype none

module touch_gesture_detector_unit #(
    parameter int unsigned MAX_CLICKS = 15
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_cfg_we,
    input  wire [tgd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire [tgd_pkg::CFG_W-1:0]   i_cfg_data,
    tgd_in_if.sink                     i_in,
    tgd_out_if.source                  o_out
);
    import tgd_pkg::*;

    localparam int unsigned CW = $clog2(MAX_CLICKS + 1);
    localparam logic [CW-1:0] CLICK_MAX = CW'(MAX_CLICKS);

    logic [CFG_W-1:0]  r_debounce;
    logic [CFG_W-1:0]  r_long_press;
    logic [CFG_W-1:0]  r_multi_click;

    logic              r_in_valid;
    logic              r_level_in;
    logic [TIME_W-1:0] r_now;

    logic              r_last_level;
    logic [TIME_W-1:0] r_last_change;
    logic [TIME_W-1:0] r_press_start;
    logic              r_press_pending;
    logic              r_long_fired;
    logic              r_long_active;
    logic [CW-1:0]     r_clicks;

    logic               r_out_valid;
    t_event_kind        r_event_kind;
    logic [COUNT_W-1:0] r_click_count;

    logic              n_last_level;
    logic [TIME_W-1:0] n_last_change;
    logic [TIME_W-1:0] n_press_start;
    logic              n_press_pending;
    logic              n_long_fired;
    logic              n_long_active;
    logic [CW-1:0]     n_clicks;
    logic              n_emit;
    t_event_kind       n_event_kind;
    logic [COUNT_W-1:0] n_click_count;

    logic              advance;
    logic              rising;
    logic [TIME_W-1:0] quiet;
    logic [TIME_W-1:0] held;

    assign advance     = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || advance;

    assign o_out.valid       = r_out_valid;
    assign o_out.event_kind  = r_event_kind;
    assign o_out.click_count = r_click_count;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce    <= DEBOUNCE_RST;
            r_long_press  <= LONG_PRESS_RST;
            r_multi_click <= MULTI_CLICK_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_DEBOUNCE:    r_debounce    <= i_cfg_data;
                CFG_LONG_PRESS:  r_long_press  <= i_cfg_data;
                CFG_MULTI_CLICK: r_multi_click <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_level_in <= i_in.touch_level;
            r_now      <= i_in.now_ms;
        end
    end

    // gesture evaluation
    always_comb begin
        rising          = r_level_in && !r_last_level;
        n_last_level    = r_level_in;
        n_last_change   = (r_level_in != r_last_level) ? r_now : r_last_change;
        n_press_start   = rising ? r_now : r_press_start;
        n_press_pending = rising ? 1'b1 : r_press_pending;
        n_long_fired    = rising ? 1'b0 : r_long_fired;
        n_long_active   = rising ? 1'b0 : r_long_active;
        n_clicks        = r_clicks;
        n_emit          = 1'b0;
        n_event_kind    = EV_SERIES_END;
        n_click_count   = '0;

        quiet = r_now - n_last_change;
        held  = r_now - n_press_start;

        if (!r_level_in && quiet > TIME_W'(r_debounce) && n_long_active) begin
            n_long_active   = 1'b0;
            n_press_pending = 1'b0;
            n_emit          = 1'b1;
            n_event_kind    = EV_LONG_END;
        end else begin
            if (!r_level_in && quiet > TIME_W'(r_debounce)) begin
                if (n_press_pending && !n_long_fired && r_clicks < CLICK_MAX) begin
                    n_clicks = r_clicks + CW'(1);
                end
                n_press_pending = 1'b0;
            end
            if (r_level_in && n_press_pending && !n_long_fired
                    && held >= TIME_W'(r_long_press)) begin
                n_long_fired  = 1'b1;
                n_long_active = 1'b1;
                n_clicks      = '0;
                n_emit        = 1'b1;
                n_event_kind  = EV_LONG_START;
            end else if (n_clicks != '0 && quiet > TIME_W'(r_multi_click)) begin
                n_click_count = COUNT_W'(n_clicks);
                n_clicks      = '0;
                n_emit        = 1'b1;
                n_event_kind  = EV_SERIES_END;
            end
        end
    end

    // tracking state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_level    <= 1'b0;
            r_last_change   <= '0;
            r_press_start   <= '0;
            r_press_pending <= 1'b0;
            r_long_fired    <= 1'b0;
            r_long_active   <= 1'b0;
            r_clicks        <= '0;
        end else if (advance) begin
            r_last_level    <= n_last_level;
            r_last_change   <= n_last_change;
            r_press_start   <= n_press_start;
            r_press_pending <= n_press_pending;
            r_long_fired    <= n_long_fired;
            r_long_active   <= n_long_active;
            r_clicks        <= n_clicks;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= n_emit;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && n_emit) begin
            r_event_kind  <= n_event_kind;
            r_click_count <= n_click_count;
        end
    end

endmodule

`default_nettype wire

// ===== test/tb_touch_gesture_detector_unit.sv =====
// testbench for touch_gesture_detector_unit: gesture scoreboard with random polls and stalls
`timescale 1ns / 100ps

module tb_touch_gesture_detector_unit;
    import tgd_pkg::*;

    localparam int unsigned MAX_CLICKS   = 15;
    localparam int unsigned DRAIN_CYCLES = 4;
    localparam int          RUN_LIMIT_NS = 4_000_000;

    typedef struct packed {
        t_event_kind        kind;
        logic [COUNT_W-1:0] count;
    } t_gesture_event;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    tgd_in_if  poll_if ();
    tgd_out_if event_if ();

    touch_gesture_detector_unit #(
        .MAX_CLICKS (MAX_CLICKS)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (poll_if),
        .o_out      (event_if)
    );

    // predicted pad tracking state and thresholds
    logic [CFG_W-1:0]  thr_debounce;
    logic [CFG_W-1:0]  thr_long;
    logic [CFG_W-1:0]  thr_multi;
    logic              trk_level;
    logic [TIME_W-1:0] trk_change_ms;
    logic [TIME_W-1:0] trk_press_ms;
    logic              trk_pending;
    logic              trk_long_fired;
    logic              trk_long_active;
    int unsigned       trk_clicks;

    t_gesture_event    expected_events[$];
    logic [TIME_W-1:0] pad_time;
    bit                steady;
    int unsigned       stall_request;
    int                error_count;
    int unsigned       polls_sent;
    int unsigned       settings_used;
    int unsigned       kind_seen[3];
    int unsigned       top_count;

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    function automatic void reset_tracker();
        thr_debounce    = DEBOUNCE_RST;
        thr_long        = LONG_PRESS_RST;
        thr_multi       = MULTI_CLICK_RST;
        trk_level       = 1'b0;
        trk_change_ms   = '0;
        trk_press_ms    = '0;
        trk_pending     = 1'b0;
        trk_long_fired  = 1'b0;
        trk_long_active = 1'b0;
        trk_clicks      = 0;
    endfunction

    function automatic void queue_gesture(input t_event_kind kind, input int unsigned count);
        t_gesture_event ev;
        ev.kind  = kind;
        ev.count = COUNT_W'(count);
        expected_events.insert(expected_events.size(), ev);
    endfunction

    function automatic void track_touch(input logic lvl, input logic [TIME_W-1:0] t);
        logic [TIME_W-1:0] quiet;
        logic [TIME_W-1:0] held;
        if (lvl != trk_level) begin
            trk_change_ms = t;
            trk_level     = lvl;
            if (lvl) begin
                trk_press_ms    = t;
                trk_pending     = 1'b1;
                trk_long_fired  = 1'b0;
                trk_long_active = 1'b0;
            end
        end
        quiet = t - trk_change_ms;
        held  = t - trk_press_ms;
        if (!lvl && quiet > thr_debounce) begin
            if (trk_long_active) begin
                trk_long_active = 1'b0;
                trk_pending     = 1'b0;
                queue_gesture(EV_LONG_END, 0);
                return;
            end
            if (trk_pending && !trk_long_fired && trk_clicks < MAX_CLICKS)
                trk_clicks++;
            trk_pending = 1'b0;
        end
        if (lvl && trk_pending && !trk_long_fired && held >= thr_long) begin
            trk_long_fired  = 1'b1;
            trk_long_active = 1'b1;
            trk_clicks      = 0;
            queue_gesture(EV_LONG_START, 0);
            return;
        end
        if (trk_clicks > 0 && quiet > thr_multi) begin
            queue_gesture(EV_SERIES_END, trk_clicks);
            trk_clicks = 0;
        end
    endfunction

    // entered and left at a falling edge
    task automatic send_poll(input logic lvl, input logic [TIME_W-1:0] t);
        while (!steady && $urandom_range(99) < 12) begin
            poll_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        poll_if.valid       <= 1'b1;
        poll_if.touch_level <= lvl;
        poll_if.now_ms      <= t;
        do @(posedge i_clk); while (!poll_if.ready);
        track_touch(lvl, t);
        polls_sent++;
        @(negedge i_clk);
    endtask

    task automatic poll_at(input logic lvl, input int unsigned step);
        pad_time += step;
        send_poll(lvl, pad_time);
    endtask

    task automatic drain_events();
        poll_if.valid <= 1'b0;
        while (expected_events.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic apply_thresholds(input logic [CFG_W-1:0] deb, input logic [CFG_W-1:0] lp,
                                    input logic [CFG_W-1:0] mc);
        t_cfg_idx         regs [3] = '{CFG_DEBOUNCE, CFG_LONG_PRESS, CFG_MULTI_CLICK};
        logic [CFG_W-1:0] vals [3];
        vals = '{deb, lp, mc};
        for (int i = 0; i < 3; i++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= regs[i];
            i_cfg_data <= vals[i];
            @(negedge i_clk);
        end
        i_cfg_we     <= 1'b0;
        thr_debounce = deb;
        thr_long     = lp;
        thr_multi    = mc;
        settings_used++;
    endtask

    task automatic gesture_tap();
        int unsigned n;
        n = $urandom_range(2);
        poll_at(1'b1, $urandom_range(thr_multi));
        repeat (n) poll_at(1'b1, $urandom_range(thr_long / 3));
        poll_at(1'b0, $urandom_range(thr_long / 3));
        n = $urandom_range(2, 1);
        repeat (n) poll_at(1'b0, $urandom_range(2 * thr_debounce + 2));
    endtask

    task automatic gesture_burst(input int unsigned clicks);
        int unsigned settle;
        repeat (clicks) begin
            if (thr_multi > thr_debounce)
                settle = $urandom_range(thr_multi, thr_debounce + 1);
            else
                settle = thr_debounce + 1;
            poll_at(1'b1, $urandom_range(thr_multi));
            poll_at(1'b0, $urandom_range(thr_multi));
            poll_at(1'b0, settle);
        end
    endtask

    task automatic gesture_long_hold();
        int unsigned n;
        n = $urandom_range(3, 1);
        poll_at(1'b1, $urandom_range(thr_multi));
        repeat (n) poll_at(1'b1, $urandom_range(thr_long, thr_long / 2));
        poll_at(1'b0, $urandom_range(thr_debounce));
        poll_at(1'b0, $urandom_range(2 * thr_debounce + 2, thr_debounce));
    endtask

    task automatic gesture_quiet();
        int unsigned n;
        n = $urandom_range(2, 1);
        repeat (n) poll_at(1'b0, $urandom_range(2 * thr_multi + 2));
    endtask

    task automatic gesture_bounce();
        int unsigned n;
        n = $urandom_range(6, 2);
        repeat (n) poll_at(1'($urandom_range(1)), $urandom_range(thr_debounce / 2 + 1));
    endtask

    task automatic gesture_noise();
        if ($urandom_range(1))
            pad_time = $urandom();
        else
            pad_time -= $urandom_range(thr_multi + 100);
        send_poll(1'($urandom_range(1)), pad_time);
    endtask

    task automatic run_gestures(input int unsigned poll_goal);
        int unsigned stop_at;
        int unsigned pick;
        stop_at = polls_sent + poll_goal;
        while (polls_sent < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 35)
                gesture_tap();
            else if (pick < 52)
                gesture_burst($urandom_range(20, 2));
            else if (pick < 68)
                gesture_long_hold();
            else if (pick < 80)
                gesture_quiet();
            else if (pick < 92)
                gesture_bounce();
            else
                gesture_noise();
        end
    endtask

    // press starting at time zero, then a series of one
    task automatic test_single_click();
        send_poll(1'b1, 32'd0);
        send_poll(1'b1, 32'd100);
        send_poll(1'b0, 32'd150);
        send_poll(1'b0, 32'd201);
        send_poll(1'b0, 32'd602);
    endtask

    task automatic test_long_press();
        send_poll(1'b1, 32'd700);
        send_poll(1'b1, 32'd1700);
        send_poll(1'b1, 32'd1800);
        send_poll(1'b0, 32'd1900);
        send_poll(1'b0, 32'd1951);
    endtask

    task automatic test_time_wrap();
        send_poll(1'b1, 32'hFFFF_FFF0);
        send_poll(1'b0, 32'hFFFF_FFF8);
        send_poll(1'b0, 32'h0000_0030);
        send_poll(1'b0, 32'h0000_0300);
    endtask

    // timestamps running backwards give huge wrapped differences
    task automatic test_backwards_time();
        send_poll(1'b1, 32'h0000_0100);
        send_poll(1'b1, 32'h0000_0080);
        send_poll(1'b0, 32'h0000_0090);
        send_poll(1'b0, 32'hFFFF_FFFF);
    endtask

    task automatic test_zero_thresholds();
        drain_events();
        apply_thresholds('0, '0, '0);
        pad_time = 32'h0000_5000;
        poll_at(1'b1, 0);
        poll_at(1'b0, 1);
        poll_at(1'b0, 1);
    endtask

    // receiver holds off while every other poll fires a long press
    task automatic test_backpressure();
        stall_request = 300;
        for (int i = 0; i < 40; i++)
            poll_at(i % 2 == 0, 1);
        drain_events();
    endtask

    task automatic test_random_phases();
        logic [CFG_W-1:0] deb;
        logic [CFG_W-1:0] lp;
        logic [CFG_W-1:0] mc;
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin
                    deb = DEBOUNCE_RST; lp = LONG_PRESS_RST; mc = MULTI_CLICK_RST;
                end
                1: begin
                    deb = CFG_W'($urandom_range(20)); lp = CFG_W'($urandom_range(200, 30));
                    mc = CFG_W'($urandom_range(100, 25));
                end
                2: begin
                    deb = '0; lp = '0; mc = '0;
                end
                3: begin
                    deb = '1; lp = '1; mc = '1;
                end
                4: begin
                    deb = CFG_W'($urandom()); lp = CFG_W'($urandom());
                    mc = CFG_W'($urandom());
                end
                default: begin
                    deb = '0; lp = '1; mc = 16'd1;
                end
            endcase
            drain_events();
            apply_thresholds(deb, lp, mc);
            if (phase == 4)
                pad_time = 32'hFFFF_0000 + $urandom_range(16'hFFFF);
            steady = (phase == 1);
            run_gestures(40);
            if (phase == 3)
                drain_events();
            run_gestures(40);
            steady = 1'b0;
        end
    endtask

    always @(posedge i_clk) begin : check_events
        t_gesture_event want;
        if (i_rst_n && event_if.valid && event_if.ready) begin
            if (expected_events.size() == 0) begin
                $error("event with nothing expected: event_kind %0d click_count %0d",
                       event_if.event_kind, event_if.click_count);
                error_count++;
            end else begin
                want = expected_events.pop_front();
                if (event_if.event_kind !== want.kind) begin
                    $error("event_kind: expected %0d, got %0d", want.kind, event_if.event_kind);
                    error_count++;
                end
                if (event_if.click_count !== want.count) begin
                    $error("click_count: expected %0d, got %0d", want.count,
                           event_if.click_count);
                    error_count++;
                end
                kind_seen[int'(want.kind)]++;
                if (want.kind == EV_SERIES_END && want.count > top_count)
                    top_count = want.count;
            end
        end
    end

    initial begin : event_sink
        int unsigned hold_left;
        hold_left      = 0;
        event_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_request != 0) begin
                hold_left     = stall_request;
                stall_request = 0;
            end
            if (hold_left != 0) begin
                hold_left--;
                event_if.ready <= 1'b0;
            end else begin
                event_if.ready <= steady || ($urandom_range(99) >= 12);
            end
        end
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_idx           = CFG_DEBOUNCE;
        i_cfg_data          = '0;
        poll_if.valid       = 1'b0;
        poll_if.touch_level = 1'b0;
        poll_if.now_ms      = '0;
        steady              = 1'b0;
        stall_request       = 0;
        error_count         = 0;
        polls_sent          = 0;
        settings_used       = 1;
        top_count           = 0;
        pad_time            = '0;
        reset_tracker();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_single_click();
        test_long_press();
        test_time_wrap();
        test_backwards_time();
        test_zero_thresholds();
        test_backpressure();
        test_random_phases();
        drain_events();

        $display("covered %0d polls across %0d threshold settings", polls_sent, settings_used);
        $display("events: %0d series ends (largest count %0d), %0d long presses, %0d releases",
                 kind_seen[0], top_count, kind_seen[1], kind_seen[2]);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
